// File: hw/rtl/bmh_pkg.sv
package bmh_pkg;

  localparam int Depth = 256;
  localparam int KeyW = 32;
  localparam int PayW = 32;
  localparam int AddrW = $clog2(Depth);
  localparam int CntW = AddrW + 1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  typedef struct packed {
    logic                   kind;
    logic signed [KeyW-1:0] key;
    logic [PayW-1:0]        payload;
  } in_item_t;

  typedef struct packed {
    logic [31:0]   removed_payload;
    logic [1:0]    status;
    logic [CntW-1:0] occupancy;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_RM_LAST,
    S_DN_RD,
    S_DN_RDR,
    S_DN_CMP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic     start;
    logic     up_rd;
    logic     up_cmp;
    logic     rm_rd;
    logic     rm_last;
    logic     dn_rd;
    logic     dn_rdr;
    logic     dn_cmp;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic is_remove;
    logic refused;
    logic up_more;
    logic dn_more;
  } sts_t;

endpackage

// File: hw/rtl/bmh_ctrl.sv
module bmh_ctrl import bmh_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (sts.refused) begin
          state_nxt = S_OUT;
        end else if (sts.is_remove) begin
          cmd.rm_rd = 1'b1;
          state_nxt = S_RM_LAST;
        end else if (sts.up_more) begin
          cmd.up_rd = 1'b1;
          state_nxt = S_UP_CMP;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_UP_CMP: begin
        cmd.up_cmp = 1'b1;
        state_nxt = S_UP_RD;
      end
      S_RM_LAST: begin
        cmd.rm_last = 1'b1;
        state_nxt = S_DN_RD;
      end
      S_DN_RD: begin
        if (sts.dn_more) begin
          cmd.dn_rd = 1'b1;
          state_nxt = S_DN_RDR;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DN_RDR: begin
        cmd.dn_rdr = 1'b1;
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd.dn_cmp = 1'b1;
        state_nxt = S_DN_RD;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/bmh_dp.sv
module bmh_dp import bmh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  logic       cfg_valid,
  input  logic [8:0] cfg_data,
  input  cmd_t       cmd,
  output sts_t       sts,
  output out_item_t  out_data
);

  logic [KeyW-1:0] key_mem [Depth];
  logic [PayW-1:0] pay_mem [Depth];

  logic [8:0]      cap_r;
  logic [CntW-1:0] cnt_r;
  logic [AddrW-1:0] at_r;
  logic [KeyW-1:0] mk_r;
  logic [PayW-1:0] mp_r;
  logic            rm_r, ref_r;
  logic [PayW-1:0] rem_r;
  logic [1:0]      stat_r;
  logic [KeyW-1:0] hk_r, lk_r;
  logic [PayW-1:0] hp_r, lp_r;
  logic            up_done_r, dn_done_r;

  logic [CntW-1:0] cap_eff;
  logic [AddrW-1:0] par;
  logic [CntW:0]   lc, rc;
  logic            take_rc;
  logic [AddrW-1:0] pick;
  logic [KeyW-1:0] pk;
  logic [PayW-1:0] pp;

  logic            we;
  logic [AddrW-1:0] wa;
  logic [KeyW-1:0] wk;
  logic [PayW-1:0] wp;
  logic [AddrW-1:0] ra;

  assign cap_eff = (cap_r > 9'(Depth)) ? CntW'(Depth) : CntW'(cap_r);
  assign par = (at_r - AddrW'(1)) >> 1;
  assign lc = {1'b0, at_r, 1'b1};
  assign rc = {1'b0, at_r, 1'b0} + (CntW+1)'(2);
  // hk_r/hp_r hold the left child, lk_r/lp_r the freshly read right child
  assign take_rc = (rc < (CntW+1)'(cnt_r)) && ($signed(lk_r) < $signed(hk_r));
  assign pick = take_rc ? AddrW'(rc) : AddrW'(lc);
  assign pk = take_rc ? lk_r : hk_r;
  assign pp = take_rc ? lp_r : hp_r;

  assign sts.is_remove = rm_r;
  assign sts.refused   = ref_r;
  assign sts.up_more   = !up_done_r && (at_r != '0);
  assign sts.dn_more   = !dn_done_r && (lc < (CntW+1)'(cnt_r));

  always_comb begin
    we = 1'b0;
    wa = at_r;
    wk = mk_r;
    wp = mp_r;
    ra = '0;
    if (cmd.up_rd) begin
      ra = par;
    end
    if (cmd.dn_rd) begin
      ra = AddrW'(lc);
    end
    if (cmd.dn_rdr) begin
      ra = AddrW'(rc);
    end
    if (cmd.rm_rd) begin
      ra = '0;
    end
    if (cmd.rm_last) begin
      ra = AddrW'(cnt_r);
    end
    if (cmd.up_cmp) begin
      we = 1'b1;
      if ($signed(mk_r) < $signed(lk_r)) begin
        wk = lk_r;
        wp = lp_r;
      end
    end
    if (cmd.dn_cmp) begin
      we = 1'b1;
      if ($signed(mk_r) > $signed(pk)) begin
        wk = pk;
        wp = pp;
      end
    end
    if (cmd.finish && !rm_r && !ref_r) begin
      we = 1'b1;
    end
    if (cmd.finish && rm_r && !ref_r && (cnt_r != '0)) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[wa] <= wk;
      pay_mem[wa] <= wp;
    end
    lk_r <= key_mem[ra];
    lp_r <= pay_mem[ra];
    if (cmd.dn_rdr) begin
      hk_r <= lk_r;
      hp_r <= lp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 9'd256;
      cnt_r <= '0;
      rm_r <= 1'b0;
      ref_r <= 1'b0;
      stat_r <= ST_DONE;
      up_done_r <= 1'b0;
      dn_done_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      if (cmd.start) begin
        rm_r <= in_data.kind;
        mk_r <= in_data.key;
        mp_r <= in_data.payload;
        rem_r <= '0;
        up_done_r <= 1'b0;
        dn_done_r <= 1'b0;
        at_r <= '0;
        ref_r <= 1'b0;
        stat_r <= ST_DONE;
        if (in_data.kind == KIND_INSERT) begin
          if (cnt_r >= cap_eff) begin
            ref_r <= 1'b1;
            stat_r <= ST_FULL;
          end else begin
            at_r <= AddrW'(cnt_r);
            cnt_r <= cnt_r + CntW'(1);
          end
        end else if (cnt_r == '0) begin
          ref_r <= 1'b1;
          stat_r <= ST_EMPTY;
        end else begin
          cnt_r <= cnt_r - CntW'(1);
        end
      end
      if (cmd.up_cmp) begin
        if ($signed(mk_r) < $signed(lk_r)) begin
          at_r <= par;
        end else begin
          up_done_r <= 1'b1;
        end
      end
      if (cmd.rm_last) begin
        rem_r <= lp_r;
      end
      if (cmd.dn_cmp) begin
        if ($signed(mk_r) > $signed(pk)) begin
          at_r <= pick;
        end else begin
          dn_done_r <= 1'b1;
        end
      end
      if (cmd.rm_last && cnt_r != '0) begin
        mk_r <= key_mem[AddrW'(cnt_r)];
        mp_r <= pay_mem[AddrW'(cnt_r)];
      end
    end
  end

  assign out_data.removed_payload = rem_r;
  assign out_data.status = stat_r;
  assign out_data.occupancy = cnt_r;

endmodule

// File: hw/rtl/binary_min_heap_priority_queue.sv
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   in_item_t {kind, key, payload}
// out_     output     out_valid/out_stall out_item_t {removed_payload, status, occupancy}
// cfg_     input      cfg_valid/cfg_ready 9-bit capacity_limit
// One transaction at a time; an insert compares its way up parent by parent, and a
// remove moves the last entry to the root and examines one level at a time on the way down.
// One memory read per cycle sets the pace.
// Synchronous reset empties the heap and sets the capacity to 256.
// A stalled result holds; no new transaction is taken until it leaves.
module binary_min_heap_priority_queue import bmh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bmh_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  bmh_dp u_dp (
    .clk, .rst_n, .in_data, .cfg_valid, .cfg_data, .cmd, .sts, .out_data
  );

  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_data.occupancy <= CntW'(Depth))
    else $error("occupancy beyond depth");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

endmodule

// File: test/binary_min_heap_priority_queue_test.sv
`timescale 1ns / 100ps

module binary_min_heap_priority_queue_test;
  import bmh_pkg::*;

  class heap_scoreboard;
    logic signed [KeyW-1:0] keys[$];
    logic [PayW-1:0] pays[$];
    int unsigned capacity;
    out_item_t awaited[$];
    int mismatches;
    int checked;

    function void reset_state();
      keys.delete();
      pays.delete();
      capacity = 256;
    endfunction

    function void note_request(in_item_t req);
      out_item_t res;
      int unsigned cap;
      int at, up, lc, rc, pick;
      logic signed [KeyW-1:0] tk;
      logic [PayW-1:0] tp;
      cap = (capacity > Depth) ? Depth : capacity;
      res = '0;
      if (req.kind == KIND_INSERT) begin
        if (keys.size() >= cap) begin
          res.status = ST_FULL;
        end else begin
          keys.push_back(req.key);
          pays.push_back(req.payload);
          at = keys.size() - 1;
          while (at > 0) begin
            up = (at - 1) / 2;
            if (keys[at] < keys[up]) begin
              tk = keys[at]; keys[at] = keys[up]; keys[up] = tk;
              tp = pays[at]; pays[at] = pays[up]; pays[up] = tp;
              at = up;
            end else begin
              break;
            end
          end
        end
      end else begin
        if (keys.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.removed_payload = pays[0];
          keys[0] = keys[keys.size() - 1];
          pays[0] = pays[pays.size() - 1];
          void'(keys.pop_back());
          void'(pays.pop_back());
          at = 0;
          forever begin
            lc = 2 * at + 1;
            rc = 2 * at + 2;
            if (lc >= keys.size()) break;
            pick = lc;
            if (rc < keys.size() && keys[rc] < keys[lc]) pick = rc;
            if (keys[at] > keys[pick]) begin
              tk = keys[at]; keys[at] = keys[pick]; keys[pick] = tk;
              tp = pays[at]; pays[at] = pays[pick]; pays[pick] = tp;
              at = pick;
            end else begin
              break;
            end
          end
        end
      end
      res.occupancy = CntW'(keys.size());
      awaited.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", got);
        return;
      end
      exp = awaited.pop_front();
      checked++;
      if (got.removed_payload !== exp.removed_payload || got.status !== exp.status ||
          got.occupancy !== exp.occupancy) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected payload %h status %0d occupancy %0d, got %h %0d %0d",
                   exp.removed_payload, exp.status, exp.occupancy,
                   got.removed_payload, got.status, got.occupancy);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [8:0] cfg_data = 9'd256;

  heap_scoreboard heap_model;
  int unsigned cycle_count = 0;
  int sent = 0;
  int hold_off = 0;
  bit long_hold_done = 1'b0;
  int full_drops = 0;
  int empty_removes = 0;

  binary_min_heap_priority_queue DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (out_data.status == ST_FULL) full_drops++;
      if (out_data.status == ST_EMPTY) empty_removes++;
      heap_model.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else if (!long_hold_done && sent >= 330) begin
      long_hold_done <= 1'b1;
      hold_off <= 300;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 2) begin
      hold_off <= $urandom_range(20, 80);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic write_capacity(input logic [8:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    heap_model.capacity = value;
  endtask

  task automatic send_request(input kind_t kind, input logic [31:0] key,
                              input logic [31:0] payload, input bit gaps);
    in_item_t req;
    int gap;
    req.kind = kind;
    req.key = key;
    req.payload = payload;
    gap = 0;
    if (gaps) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    heap_model.note_request(req);
    sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (heap_model.awaited.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic random_phase(input int count, input int remove_pct);
    logic [31:0] k;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: k = $urandom_range(0, 15);
        1: k = $urandom();
        2: k = {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom())};
        default: k = 32'($signed($urandom_range(0, 20)) - 10);
      endcase
      if ($urandom_range(0, 99) < remove_pct)
        send_request(KIND_REMOVE, $urandom(), $urandom(), 1'b1);
      else
        send_request(KIND_INSERT, k, $urandom(), 1'b1);
    end
  endtask

  initial begin
    heap_model = new();
    heap_model.reset_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(KIND_REMOVE, 32'h0, 32'h0, 1'b0);
    send_request(KIND_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_request(KIND_INSERT, 32'h8000_0000, 32'h0000_0000, 1'b0);
    send_request(KIND_INSERT, 32'h0, 32'hA5A5_A5A5, 1'b0);
    send_request(KIND_INSERT, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 1'b0);
    send_request(KIND_INSERT, 32'h0, 32'h1111_1111, 1'b0);
    send_request(KIND_INSERT, 32'h8000_0000, 32'h2222_2222, 1'b0);
    for (int i = 0; i < 8; i++) send_request(KIND_REMOVE, 32'h0, 32'h0, 1'b0);
    drain();

    write_capacity(9'd1);
    send_request(KIND_INSERT, 32'd5, 32'd1, 1'b0);
    send_request(KIND_INSERT, 32'd3, 32'd2, 1'b0);
    send_request(KIND_REMOVE, 32'd0, 32'd0, 1'b0);
    drain();
    write_capacity(9'd0);
    send_request(KIND_INSERT, 32'd5, 32'd1, 1'b0);
    send_request(KIND_REMOVE, 32'd0, 32'd0, 1'b0);
    drain();
    write_capacity(9'd511);
    random_phase(300, 10);
    random_phase(60, 30);
    drain();
    write_capacity(9'd4);
    random_phase(100, 40);
    drain();
    write_capacity(9'd256);
    random_phase(400, 45);
    drain();
    write_capacity(9'd300);
    random_phase(80, 0);
    drain();
    write_capacity(9'd17);
    random_phase(200, 55);
    drain();
    write_capacity(9'd256);
    random_phase(150, 90);
    drain();

    $display("Covered %0d requests, %0d results checked, %0d full drops, %0d empty removes",
             sent, heap_model.checked, full_drops, empty_removes);
    $display("Capacity settings 0, 1, 4, 17, 256, 300 and 511 exercised");
    if (heap_model.mismatches == 0 && heap_model.awaited.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", heap_model.mismatches,
               heap_model.awaited.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/bmh_pkg.sv
hw/rtl/bmh_ctrl.sv
hw/rtl/bmh_dp.sv
hw/rtl/binary_min_heap_priority_queue.sv
test/binary_min_heap_priority_queue_test.sv
